// File: rtl/pas_pkg.sv
package pas_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int COORD_WIDTH = 24;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int PT_W        = 2 * COORD_WIDTH;
   localparam int CSR_AW      = 2;

   localparam logic [CSR_AW-1:0] REG_CENTER_X = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_CENTER_Y = CSR_AW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KREAD,
      ST_KLATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_k;
      logic latch_k;
      logic issue_j;
      logic write_rank;
      logic issue_e;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic j_last;
      logic k_last;
      logic e_last;
      logic pipe_busy;
   } status_type;

endpackage

// File: rtl/pas_ram.sv
module pas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pas_ctrl.sv
module pas_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                last_in,
   input  pas_pkg::status_type status,
   output pas_pkg::cmd_type    cmd,
   output logic                busy
);

   pas_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pas_pkg::ST_IDLE:   if (accept && last_in) state_in = pas_pkg::ST_KREAD;
         pas_pkg::ST_KREAD:  state_in = pas_pkg::ST_KLATCH;
         pas_pkg::ST_KLATCH: state_in = pas_pkg::ST_SCAN;
         pas_pkg::ST_SCAN:   if (status.j_last) state_in = pas_pkg::ST_DRAIN;
         pas_pkg::ST_DRAIN:  if (!status.pipe_busy) state_in = pas_pkg::ST_WRITE;
         pas_pkg::ST_WRITE: begin
            if (status.k_last) begin
               state_in = pas_pkg::ST_EMIT;
            end else begin
               state_in = pas_pkg::ST_KREAD;
            end
         end
         pas_pkg::ST_EMIT:   if (status.e_last) state_in = pas_pkg::ST_FLUSH;
         pas_pkg::ST_FLUSH:  state_in = pas_pkg::ST_IDLE;
         default:            state_in = pas_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         pas_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = accept;
         end
         pas_pkg::ST_KREAD:  cmd.rd_k = 1'b1;
         pas_pkg::ST_KLATCH: cmd.latch_k = 1'b1;
         pas_pkg::ST_SCAN:   cmd.issue_j = 1'b1;
         pas_pkg::ST_DRAIN:  ;
         pas_pkg::ST_WRITE:  cmd.write_rank = 1'b1;
         pas_pkg::ST_EMIT:   cmd.issue_e = 1'b1;
         pas_pkg::ST_FLUSH:  cmd.finish = 1'b1;
         default:            busy = 1'b1;
      endcase
   end

endmodule

// File: rtl/pas_dp.sv
module pas_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pas_pkg::cmd_type                    cmd,
   output pas_pkg::status_type                 status,
   input  logic                                csr_we,
   input  logic [pas_pkg::CSR_AW-1:0]          csr_addr,
   input  logic [pas_pkg::COORD_WIDTH-1:0]     csr_wdata,
   input  logic signed [pas_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pas_pkg::COORD_WIDTH-1:0] req_point_y,
   output logic                                rsp_valid,
   output logic signed [pas_pkg::COORD_WIDTH-1:0] rsp_sorted_x,
   output logic signed [pas_pkg::COORD_WIDTH-1:0] rsp_sorted_y,
   output logic                                rsp_last_out,
   output logic                                rsp_overflow
);

   localparam int CW = pas_pkg::COORD_WIDTH;
   localparam int DW = pas_pkg::DIFF_W;
   localparam int IW = pas_pkg::IDX_W;
   localparam int NW = pas_pkg::CNT_W;

   logic signed [CW-1:0] center_x_ff, center_y_ff;
   logic [NW-1:0] count_ff;
   logic          dropped_ff;
   logic [IW-1:0] k_ff, j_ff, e_ff, rank_ff;
   logic [pas_pkg::PT_W-1:0] kpt_ff;
   logic signed [DW-1:0] kdx_ff, kdy_ff;
   logic          kh_ff;

   logic          s1_v_ff, s2_v_ff, s3_v_ff;
   logic signed [DW-1:0] jdx_ff, jdy_ff;
   logic          jh_ff, jlt_ff, jh2_ff, jlt2_ff;
   logic          jlt_pre_ff;
   logic signed [pas_pkg::PROD_W-1:0] pab_ff, pba_ff;
   logic          emit_v_ff, emit_last_ff;

   logic          full;
   logic [IW-1:0] n_m1;
   logic [IW-1:0] st_rd_addr;
   logic [pas_pkg::PT_W-1:0] st_rd_data, so_rd_data;
   logic signed [DW-1:0] ddx, ddy, fdx;
   logic          dh;
   logic          bef_jk, bef_kj, hit;

   assign full = (count_ff == NW'(pas_pkg::MAX_POINTS));
   assign n_m1 = IW'(count_ff - NW'(1));

   assign status.j_last    = (j_ff == n_m1);
   assign status.k_last    = (k_ff == n_m1);
   assign status.e_last    = (e_ff == n_m1);
   assign status.pipe_busy = s1_v_ff | s2_v_ff | s3_v_ff | cmd.issue_j;

   assign st_rd_addr = cmd.rd_k ? k_ff : j_ff;

   pas_ram #(.WIDTH(pas_pkg::PT_W), .DEPTH(pas_pkg::MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load && !full),
      .wr_addr (IW'(count_ff)),
      .wr_data ({req_point_y, req_point_x}),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pas_ram #(.WIDTH(pas_pkg::PT_W), .DEPTH(pas_pkg::MAX_POINTS)) u_sorted (
      .clock   (clock),
      .wr_en   (cmd.write_rank),
      .wr_addr (rank_ff),
      .wr_data (kpt_ff),
      .rd_addr (e_ff),
      .rd_data (so_rd_data)
   );

   // offset from centre, a point on the centre counts as the positive x axis
   assign ddx = DW'($signed(st_rd_data[CW-1:0])) - DW'(center_x_ff);
   assign ddy = DW'($signed(st_rd_data[2*CW-1:CW])) - DW'(center_y_ff);
   assign fdx = (ddx == '0 && ddy == '0) ? DW'(1) : ddx;
   assign dh  = (ddy > 0) || (ddy == '0 && fdx >= 0);

   assign bef_jk = (jh2_ff != kh_ff) ? jh2_ff : (pab_ff > pba_ff);
   assign bef_kj = (jh2_ff != kh_ff) ? kh_ff  : (pba_ff > pab_ff);
   assign hit    = bef_jk || (jlt2_ff && !bef_kj);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         emit_v_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_addr == pas_pkg::REG_CENTER_X) center_x_ff <= csr_wdata;
         if (csr_we && csr_addr == pas_pkg::REG_CENTER_Y) center_y_ff <= csr_wdata;
         if (cmd.load) begin
            if (full) begin
               dropped_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + NW'(1);
            end
         end
         if (cmd.finish) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
         s1_v_ff   <= cmd.issue_j;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         emit_v_ff <= cmd.issue_e;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) k_ff <= '0;
      if (cmd.write_rank) k_ff <= k_ff + IW'(1);
      if (cmd.latch_k) begin
         kpt_ff  <= st_rd_data;
         kdx_ff  <= fdx;
         kdy_ff  <= ddy;
         kh_ff   <= dh;
         j_ff    <= '0;
         rank_ff <= '0;
         e_ff    <= '0;
      end
      if (cmd.issue_j) j_ff <= j_ff + IW'(1);
      if (cmd.issue_e) e_ff <= e_ff + IW'(1);
      emit_last_ff <= status.e_last;
      jdx_ff  <= fdx;
      jdy_ff  <= ddy;
      jh_ff   <= dh;
      jlt_ff  <= jlt_pre_ff;
      pab_ff  <= jdx_ff * kdy_ff;
      pba_ff  <= jdy_ff * kdx_ff;
      jh2_ff  <= jh_ff;
      jlt2_ff <= jlt_ff;
      if (s3_v_ff && hit) rank_ff <= rank_ff + IW'(1);
   end

   // jlt sampled with issue address, so keep it aligned to the read
   always_ff @(posedge clock) begin
      jlt_pre_ff <= (j_ff < k_ff);
   end

   assign rsp_valid    = emit_v_ff;
   assign rsp_sorted_x = so_rd_data[CW-1:0];
   assign rsp_sorted_y = so_rd_data[2*CW-1:CW];
   assign rsp_last_out = emit_v_ff & emit_last_ff;
   assign rsp_overflow = emit_v_ff & dropped_ff;

endmodule

// File: rtl/polar_angle_sort.sv
// polar_angle_sort: collects a set of points and returns them ordered
// counter-clockwise by angle about the centre held in two registers.
// input: a word is taken when start is high and busy is low; each word
// carries one point and last_in; last_in closes the set.
// while busy is low a word is taken every cycle; points past the store
// capacity are dropped and the run then shows overflow on every word.
// after the closing word busy rises: the sort ranks each point against
// every other one through the single read port of the point store and
// a compare pipe. then n result words leave on consecutive cycles,
// each marked by rsp_valid for one cycle; last_out marks the final one.
// the receiver cannot hold words off. busy falls in the cycle after
// the final word. the user writes the centre registers through
// csr_we/csr_addr/csr_wdata only while busy is low; the block does not
// enforce this. reset clears centre, fill count and overflow state.
module polar_angle_sort (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pas_pkg::CSR_AW-1:0]          csr_addr,
   input  logic [pas_pkg::COORD_WIDTH-1:0]     csr_wdata,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [pas_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pas_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   output logic signed [pas_pkg::COORD_WIDTH-1:0] rsp_sorted_x,
   output logic signed [pas_pkg::COORD_WIDTH-1:0] rsp_sorted_y,
   output logic                                rsp_last_out,
   output logic                                rsp_overflow
);

   pas_pkg::cmd_type    cmd;
   pas_pkg::status_type status;
   logic                accept;

   assign accept = start & ~busy;

   pas_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .last_in (req_last_in),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   pas_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .rsp_valid    (rsp_valid),
      .rsp_sorted_x (rsp_sorted_x),
      .rsp_sorted_y (rsp_sorted_y),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// File: rtl/pas_checker.sv
module pas_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_in,
   input logic rsp_valid,
   input logic rsp_last_out
);

   a_word_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result word while idle");

   a_end_of_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |=> !rsp_valid && !busy)
      else $error("activity after final word");

   a_close_set: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_in |=> busy) else $error("set not closed");

   a_open_set: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_in |=> !busy) else $error("busy mid set");

endmodule

bind polar_angle_sort pas_checker u_pas_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_last_in  (req_last_in),
   .rsp_valid    (rsp_valid),
   .rsp_last_out (rsp_last_out)
);

// File: bench/tb_polar_angle_sort.sv
module tb_polar_angle_sort;

   typedef logic signed [pas_pkg::COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      ovf;
   } sorted_word_type;

   typedef struct {
      coord_type       x;
      coord_type       y;
      logic            last;
      logic            has_exp;
      sorted_word_type exp;
   } stim_row_type;

   localparam logic [pas_pkg::CSR_AW-1:0] REG_SPARE_2 = pas_pkg::CSR_AW'(2);
   localparam logic [pas_pkg::CSR_AW-1:0] REG_SPARE_3 = pas_pkg::CSR_AW'(3);
   localparam coord_type C_MAX = {1'b0, {(pas_pkg::COORD_WIDTH-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(pas_pkg::COORD_WIDTH-1){1'b0}}};
   localparam int WATCH_LIMIT = 60000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [pas_pkg::CSR_AW-1:0]       csr_addr = '0;
   logic [pas_pkg::COORD_WIDTH-1:0]  csr_wdata = '0;
   logic                             start = 1'b0;
   logic                             busy;
   coord_type                        req_point_x = '0;
   coord_type                        req_point_y = '0;
   logic                             req_last_in = 1'b0;
   logic                             rsp_valid;
   coord_type                        rsp_sorted_x;
   coord_type                        rsp_sorted_y;
   logic                             rsp_last_out;
   logic                             rsp_overflow;

   polar_angle_sort i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_sorted_x(rsp_sorted_x), .rsp_sorted_y(rsp_sorted_y),
      .rsp_last_out(rsp_last_out), .rsp_overflow(rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   coord_type       centre_x = '0;
   coord_type       centre_y = '0;
   point_type       held_points[$];
   logic            held_dropped = 1'b0;
   sorted_word_type sorted_words[$];

   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int sets_done = 0;
   int overflow_sets = 0;
   int idle_cycles = 0;
   bit allow_gaps = 1'b1;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic bit earlier_angle(longint ax, longint ay, longint bx, longint by);
      bit ha, hb;
      if (ax == 0 && ay == 0) ax = 1;
      if (bx == 0 && by == 0) bx = 1;
      ha = (ay > 0) || (ay == 0 && ax >= 0);
      hb = (by > 0) || (by == 0 && bx >= 0);
      if (ha != hb) return ha;
      return ax * by > ay * bx;
   endfunction

   function automatic void predict_word(coord_type x, coord_type y, logic last);
      point_type       ranked[$];
      point_type       p;
      sorted_word_type w;
      int              j;
      if (held_points.size() < pas_pkg::MAX_POINTS) begin
         p.x = x;
         p.y = y;
         held_points.insert(held_points.size(), p);
      end else begin
         held_dropped = 1'b1;
      end
      if (!last) return;
      foreach (held_points[i]) begin
         j = ranked.size();
         while (j > 0 && earlier_angle(
                   longint'(held_points[i].x) - longint'(centre_x),
                   longint'(held_points[i].y) - longint'(centre_y),
                   longint'(ranked[j-1].x) - longint'(centre_x),
                   longint'(ranked[j-1].y) - longint'(centre_y)))
            j--;
         ranked.insert(j, held_points[i]);
      end
      foreach (ranked[i]) begin
         w.x = ranked[i].x;
         w.y = ranked[i].y;
         w.last = (i == ranked.size() - 1);
         w.ovf = held_dropped;
         sorted_words.insert(sorted_words.size(), w);
      end
      sets_done++;
      if (held_dropped) overflow_sets++;
      held_points.delete();
      held_dropped = 1'b0;
   endfunction

   task automatic send_point(coord_type x, coord_type y, logic last);
      start <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_last_in <= last;
      do @(posedge clock); while (busy);
      words_in++;
      predict_word(x, y, last);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (allow_gaps && $urandom_range(0, 5) == 0) pause($urandom_range(1, 19));
   endtask

   // centre is only touched once the block has drained
   task automatic write_csr(logic [pas_pkg::CSR_AW-1:0] addr, coord_type value);
      pause(1);
      while (sorted_words.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == pas_pkg::REG_CENTER_X) centre_x = value;
      else if (addr == pas_pkg::REG_CENTER_Y) centre_y = value;
   endtask

   function automatic coord_type pick_coord(coord_type around);
      case ($urandom_range(0, 5))
         0, 1: return coord_type'($urandom);
         2: return around + coord_type'($signed($urandom_range(0, 6)) - 3);
         3: return $urandom_range(0, 1) ? C_MAX : C_MIN;
         4: return around;
         default: return coord_type'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   task automatic send_set(int n);
      for (int i = 0; i < n; i++) begin
         send_point(pick_coord(centre_x), pick_coord(centre_y), i == n - 1);
         maybe_gap();
      end
   endtask

   // checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin
      sorted_word_type w;
      if (!reset && rsp_valid) begin
         words_out++;
         if (sorted_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_sorted_x, 0);
         end else begin
            w = sorted_words.pop_front();
            if (rsp_sorted_x !== w.x) report_mismatch("sorted_x", rsp_sorted_x, w.x);
            if (rsp_sorted_y !== w.y) report_mismatch("sorted_y", rsp_sorted_y, w.y);
            if (rsp_last_out !== w.last) report_mismatch("last_out", rsp_last_out, w.last);
            if (rsp_overflow !== w.ovf) report_mismatch("overflow", rsp_overflow, w.ovf);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("FAIL polar_angle_sort");
         $finish;
      end
   end

   function automatic stim_row_type row(coord_type x, coord_type y, logic last,
                                        logic has_exp = 0, logic ovf = 0);
      stim_row_type r;
      r.x = x;
      r.y = y;
      r.last = last;
      r.has_exp = has_exp;
      r.exp.x = x;
      r.exp.y = y;
      r.exp.last = 1'b1;
      r.exp.ovf = ovf;
      return r;
   endfunction

   initial begin
      stim_row_type    rows[$];
      sorted_word_type w;
      int              n;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-point sets: the word comes straight back
      rows = {rows, row(C_MAX, C_MAX, 1, 1)};
      rows = {rows, row(C_MIN, C_MIN, 1, 1)};
      rows = {rows, row('0, '0, 1, 1)};
      rows = {rows, row(C_MIN, C_MAX, 1, 1)};
      rows = {rows, row(C_MAX, C_MIN, 1, 1)};
      // axes, quadrants, centre point and the negative x axis
      rows = {rows, row(-1, -1, 0)};
      rows = {rows, row(0, -1, 0)};
      rows = {rows, row(-1, 0, 0)};
      rows = {rows, row(0, 0, 0)};
      rows = {rows, row(2, 0, 0)};
      rows = {rows, row(1, 1, 0)};
      rows = {rows, row(0, 1, 0)};
      rows = {rows, row(-2, 2, 0)};
      rows = {rows, row(1, 0, 1)};
      // equal angles keep arrival order
      rows = {rows, row(5, -5, 0)};
      rows = {rows, row(C_MIN, 3, 0)};
      rows = {rows, row(3, -3, 0)};
      rows = {rows, row(5, -5, 0)};
      rows = {rows, row(C_MAX, C_MAX, 1)};

      foreach (rows[i]) begin
         send_point(rows[i].x, rows[i].y, rows[i].last);
         if (rows[i].has_exp) begin
            w = sorted_words[$];
            if (w.x !== rows[i].exp.x || w.y !== rows[i].exp.y ||
                w.last !== rows[i].exp.last || w.ovf !== rows[i].exp.ovf)
               report_mismatch("table row", i, 0);
         end
         maybe_gap();
      end

      // extreme centres, unused register indexes, full and overflowing store
      write_csr(pas_pkg::REG_CENTER_X, C_MAX);
      write_csr(pas_pkg::REG_CENTER_Y, C_MIN);
      write_csr(REG_SPARE_2, coord_type'($urandom));
      send_set(pas_pkg::MAX_POINTS);
      write_csr(pas_pkg::REG_CENTER_X, C_MIN);
      write_csr(pas_pkg::REG_CENTER_Y, C_MAX);
      write_csr(REG_SPARE_3, coord_type'($urandom));
      send_set(pas_pkg::MAX_POINTS + 3);

      while (words_in < 520) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: write_csr(pas_pkg::REG_CENTER_X, coord_type'($urandom));
               1: write_csr(pas_pkg::REG_CENTER_Y, coord_type'($urandom));
               2: write_csr($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                            coord_type'($urandom));
               default: begin
                  write_csr(pas_pkg::REG_CENTER_X,
                            coord_type'($signed($urandom_range(0, 40)) - 20));
                  write_csr(pas_pkg::REG_CENTER_Y,
                            coord_type'($signed($urandom_range(0, 40)) - 20));
               end
            endcase
         end
         if (words_in > 420) allow_gaps = 1'b0;
         case ($urandom_range(0, 19))
            0: n = pas_pkg::MAX_POINTS + $urandom_range(1, 4);
            1: n = $urandom_range(20, pas_pkg::MAX_POINTS);
            default: n = $urandom_range(1, 10);
         endcase
         send_set(n);
      end
      pause(1);

      while (sorted_words.size() != 0 && idle_cycles < WATCH_LIMIT) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d points in %0d sets (%0d with dropped points), got %0d sorted words",
               words_in, sets_done, overflow_sets, words_out);
      $display("centre swept over both extremes, unused indexes written, %0d errors", errors);
      if (errors == 0 && sorted_words.size() == 0) begin
         $display("PASS polar_angle_sort");
      end else begin
         $display("FAIL polar_angle_sort");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/pas_pkg.sv
rtl/pas_ram.sv
rtl/pas_ctrl.sv
rtl/pas_dp.sv
rtl/polar_angle_sort.sv
rtl/pas_checker.sv
bench/tb_polar_angle_sort.sv
